FILE: rtl/core/llw_pkg.sv
// Package for the link liveness watchdog: sizes, reset values and the
// broadcast command and mask-chain types shared by the cells and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package llw_pkg;

    localparam int NUM_LINKS    = 36;
    localparam int COUNTER_BITS = 16;

    // fixed field widths
    localparam int OP_W     = 1;
    localparam int LINK_W   = 6;
    localparam int MASK_W   = 36;
    localparam int RELOAD_W = 16;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [RELOAD_W-1:0] RELOAD_RST = 16'd50;

    // countdown reset is the reset reload trimmed to the counter
    localparam logic [COUNTER_BITS-1:0] CNT_RST =
        COUNTER_BITS'(50 % (64'd1 << COUNTER_BITS));

    localparam logic [OP_W-1:0] OP_MSG  = 1'b0;
    localparam logic [OP_W-1:0] OP_TICK = 1'b1;

    localparam logic [0:0] REG_TIMEOUT_RELOAD = 1'b0;

    typedef struct packed {
        logic                    msg;
        logic                    tick;
        logic [COUNTER_BITS-1:0] reload;
    } t_cell_cmd;

    // masks shift one place per cell: link k ends up at bit NUM_LINKS-1-k
    typedef struct packed {
        logic [NUM_LINKS-1:0] avail;
        logic [NUM_LINKS-1:0] valid;
    } t_chain;

endpackage

`default_nettype wire

FILE: rtl/core/link_liveness_watchdog.sv
// Top level of the link liveness watchdog: command port, APB register,
// row of per-link cells and the registered result. Depends on llw_pkg, llw_cell.
`timescale 1ns / 1ps
`default_nettype none

// Link liveness watchdog. Each link has a cell holding a valid flag, a
// keepalive countdown and a refreshed mark. A message beat (operation 0)
// marks its link valid and reloads the countdown from timeout_reload; it
// gives no result. A tick beat (operation 1) updates every cell in the same
// cycle and gives one result on o_available_mask / o_valid_mask, strobed
// by o_result_valid for one cycle, the cycle after the tick is accepted.
// Cells never stall, so busy is tied low and a
// new beat is taken every cycle; results cannot be stalled and need no
// hold-off. A link that expires on a tick reads unavailable only from the
// next tick on. Messages for link indexes at or above the link count are
// dropped. timeout_reload sits at byte address 0 of the APB port; program
// it only while no tick result is pending.
module link_liveness_watchdog (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // command channel
    input  wire                          start,
    output logic                         busy,
    input  wire  [llw_pkg::OP_W-1:0]     i_operation,
    input  wire  [llw_pkg::LINK_W-1:0]   i_link_index,
    // result channel
    output logic                         o_result_valid,
    output logic [llw_pkg::MASK_W-1:0]   o_available_mask,
    output logic [llw_pkg::MASK_W-1:0]   o_valid_mask,
    // APB register port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [llw_pkg::ADDR_W-1:0]   paddr,
    input  wire  [llw_pkg::DATA_W-1:0]   pwdata,
    output logic [llw_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import llw_pkg::*;

    // ---------------- register port ----------------
    logic [RELOAD_W-1:0] r_reload;
    logic                w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload <= RELOAD_RST;
        end else if (w_wr && paddr[2] == REG_TIMEOUT_RELOAD) begin
            r_reload <= pwdata[RELOAD_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_TIMEOUT_RELOAD) begin
            prdata = DATA_W'(r_reload);
        end
    end

    // ---------------- command broadcast ----------------
    logic      w_accept;
    t_cell_cmd w_cmd;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_comb begin
        w_cmd.msg  = w_accept && (i_operation == OP_MSG);
        w_cmd.tick = w_accept && (i_operation == OP_TICK);
        // reload is zero-extended or trimmed to the counter width
        if (COUNTER_BITS >= RELOAD_W) begin
            w_cmd.reload = COUNTER_BITS'(r_reload);
        end else begin
            w_cmd.reload = r_reload[COUNTER_BITS-1:0];
        end
    end

    // ---------------- cell row ----------------
    // w_chain[k] feeds cell k; w_chain[NUM_LINKS] is the full mask pair
    t_chain w_chain [NUM_LINKS+1];

    assign w_chain[0] = '0;

    genvar k;
    generate
        for (k = 0; k < NUM_LINKS; k++) begin : g_cell
            llw_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_hit   (i_link_index == LINK_W'(k)),
                .i_chain (w_chain[k]),
                .o_chain (w_chain[k+1])
            );
        end
    endgenerate

    // ---------------- result mapping ----------------
    // undo the chain order; links past the output width are not reported,
    // output bits past the link count read available and not valid
    logic [MASK_W-1:0] w_avail;
    logic [MASK_W-1:0] w_valid;

    genvar j;
    generate
        for (j = 0; j < MASK_W; j++) begin : g_bit
            if (j < NUM_LINKS) begin : g_link
                assign w_avail[j] = w_chain[NUM_LINKS].avail[NUM_LINKS-1-j];
                assign w_valid[j] = w_chain[NUM_LINKS].valid[NUM_LINKS-1-j];
            end else begin : g_pad
                assign w_avail[j] = 1'b1;
                assign w_valid[j] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= w_cmd.tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.tick) begin
            o_available_mask <= w_avail;
            o_valid_mask     <= w_valid;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/llw_cell.sv
// One link's liveness record: valid flag, countdown and refreshed mark.
// Takes the broadcast command, appends its bits to the mask chain.
// Depends on llw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module llw_cell (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  llw_pkg::t_cell_cmd i_cmd,
    input  wire                i_hit,
    input  llw_pkg::t_chain    i_chain,
    output llw_pkg::t_chain    o_chain
);
    import llw_pkg::*;

    logic                    r_valid, n_valid;
    logic [COUNTER_BITS-1:0] r_cnt, n_cnt;
    logic                    r_ref, n_ref;

    always_comb begin
        n_valid = r_valid;
        n_cnt   = r_cnt;
        n_ref   = r_ref;
        if (i_cmd.msg && i_hit) begin
            n_valid = 1'b1;
            n_cnt   = i_cmd.reload;
            n_ref   = 1'b1;
        end else if (i_cmd.tick) begin
            n_ref = 1'b0;
            if (!r_ref && r_valid) begin
                if (r_cnt == '0) begin
                    n_valid = 1'b0;
                end else begin
                    n_cnt = r_cnt - COUNTER_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b1;
            r_cnt   <= CNT_RST;
            r_ref   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
            r_ref   <= n_ref;
        end
    end

    // available = refreshed or still valid before this tick's expiry
    always_comb begin
        o_chain.avail = (i_chain.avail << 1) | NUM_LINKS'(r_ref | r_valid);
        o_chain.valid = (i_chain.valid << 1) | NUM_LINKS'(n_valid);
    end

endmodule

`default_nettype wire

FILE: rtl/core/llw_checker.sv
// Port-level checker for the link liveness watchdog, bound to the top level.
// Depends on llw_pkg and link_liveness_watchdog.
`timescale 1ns / 1ps
`default_nettype none

module llw_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    input  wire                          busy,
    input  wire  [llw_pkg::OP_W-1:0]     i_operation,
    input  wire                          o_result_valid,
    input  wire  [llw_pkg::MASK_W-1:0]   o_available_mask,
    input  wire  [llw_pkg::MASK_W-1:0]   o_valid_mask
);
    import llw_pkg::*;

    // busy is never raised
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("busy raised");

    a_tick_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == OP_TICK) |=> o_result_valid)
        else $error("tick without result");

    a_result_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy && i_operation == OP_TICK))
        else $error("result without tick");

    // a link valid after a tick was refreshed or valid before it
    a_valid_implies_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ((o_valid_mask & ~o_available_mask) == '0))
        else $error("valid link reported unavailable");

endmodule

bind link_liveness_watchdog llw_checker u_llw_checker (.*);

`default_nettype wire
